### src/hpwm_pkg.sv
// Shared constants and types for the high-resolution PWM duty / sigma-delta block.
// Used by hires_pwm_duty_sigma_delta. No dependencies.
`default_nettype none

package hpwm_pkg;

  localparam int SIGMA_FRAC_BITS_DEF = 16;

  localparam int DUTY_W   = 32;
  localparam int PERIOD_W = 16;
  localparam int SCALE_W  = 16;
  localparam int PROD_W   = DUTY_W + PERIOD_W;
  localparam int COARSE_W = 16;
  localparam int STEP_W   = 8;
  localparam int FINE_W   = 2 * STEP_W;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_W      = COARSE_W + 2 * STEP_W;

  // Shift-add passes per multiply: one per multiplier bit.
  localparam int MUL_STEPS = PERIOD_W;
  localparam int CNT_W     = $clog2(MUL_STEPS);

  localparam logic [PERIOD_W-1:0] MIN_PERIOD    = 16'd16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'hFFFF;
  localparam logic [SCALE_W-1:0]  SCALE_RESET   = 16'h0000;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEP_SCALE    = 8'd1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL1 = 6'b000010,
    ST_MUL2 = 6'b000100,
    ST_SIG1 = 6'b001000,
    ST_SIG2 = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

### src/hires_pwm_duty_sigma_delta.sv
// Top level of the high-resolution PWM duty calculator with delta-sigma fine-step dither.
// Depends on hpwm_pkg.
`default_nettype none

// One duty item per PWM period. The duty (0.32) is multiplied by the period
// (clamped to at least 16) on a single shift-add unit, one multiplier bit per
// cycle; the low 32 product bits are then multiplied by mep_scale on the same
// unit. Two delta-sigma steps on the fraction byte follow, and the result is
// loaded into the output register once the output is free. The input is
// ready again in the same cycle that the result appears: the block holds one
// item at a time and takes no new one until the last result is loaded. Config
// writes are always accepted and must be made while the block is idle.
module hires_pwm_duty_sigma_delta #(
  parameter int SIGMA_FRAC_BITS = hpwm_pkg::SIGMA_FRAC_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  // duty_ratio [31:0]
  input  wire  [hpwm_pkg::DUTY_W-1:0]      s_tdata,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // coarse_count [15:0], fine_step_a [23:16], fine_step_b [31:24]
  output logic [hpwm_pkg::OUT_W-1:0]       m_tdata,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [hpwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [hpwm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int ACC_W = SIGMA_FRAC_BITS + 2;
  localparam logic [ACC_W-1:0] ACC_INIT = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] DELTA    = ACC_W'(3) << SIGMA_FRAC_BITS;

  hpwm_pkg::state_t state, state_next;

  logic [hpwm_pkg::PERIOD_W-1:0] period_count;
  logic [hpwm_pkg::SCALE_W-1:0]  mep_scale;

  // shared shift-add multiplier
  logic [hpwm_pkg::PROD_W-1:0]   prod;
  logic [hpwm_pkg::DUTY_W-1:0]   mcand;
  logic [hpwm_pkg::PERIOD_W-1:0] mplier;
  logic [hpwm_pkg::CNT_W-1:0]    cnt;
  logic [hpwm_pkg::DUTY_W:0]     mul_sum;
  logic [hpwm_pkg::PROD_W-1:0]   mul_step;
  logic                          mul_last;

  logic [hpwm_pkg::COARSE_W-1:0] coarse;
  logic [hpwm_pkg::FINE_W-1:0]   fine;

  logic [ACC_W-1:0]              sigma_accum;
  logic [ACC_W-1:0]              sigma_sum;
  logic                          swap_toggle;
  logic                          first_bit;

  logic [hpwm_pkg::STEP_W-1:0]   base;
  logic [hpwm_pkg::STEP_W-1:0]   step_first;
  logic [hpwm_pkg::STEP_W-1:0]   step_second;
  logic                          in_take;
  logic                          out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == hpwm_pkg::ST_IDLE);
  assign in_take   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign mul_sum  = {1'b0, prod[hpwm_pkg::PROD_W-1:hpwm_pkg::PERIOD_W]}
                  + {1'b0, (mplier[0] ? mcand : {hpwm_pkg::DUTY_W{1'b0}})};
  assign mul_step = {mul_sum, prod[hpwm_pkg::PERIOD_W-1:1]};
  assign mul_last = (cnt == hpwm_pkg::CNT_W'(hpwm_pkg::MUL_STEPS - 1));

  // feedback always follows the current top bit
  assign sigma_sum = sigma_accum + ACC_W'(fine[hpwm_pkg::STEP_W-1:0])
                   + (sigma_accum[ACC_W-1] ? DELTA : {ACC_W{1'b0}});

  assign base        = fine[hpwm_pkg::FINE_W-1:hpwm_pkg::STEP_W];
  assign step_first  = base + hpwm_pkg::STEP_W'(first_bit);
  assign step_second = base + hpwm_pkg::STEP_W'(sigma_accum[ACC_W-1]);

  always_comb begin
    state_next = state;
    unique case (state)
      hpwm_pkg::ST_IDLE: if (in_take) state_next = hpwm_pkg::ST_MUL1;
      hpwm_pkg::ST_MUL1: if (mul_last) state_next = hpwm_pkg::ST_MUL2;
      hpwm_pkg::ST_MUL2: if (mul_last) state_next = hpwm_pkg::ST_SIG1;
      hpwm_pkg::ST_SIG1: state_next = hpwm_pkg::ST_SIG2;
      hpwm_pkg::ST_SIG2: state_next = hpwm_pkg::ST_FIN;
      hpwm_pkg::ST_FIN:  if (out_free) state_next = hpwm_pkg::ST_IDLE;
      default:           state_next = hpwm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= hpwm_pkg::ST_IDLE;
      period_count <= hpwm_pkg::PERIOD_RESET;
      mep_scale    <= hpwm_pkg::SCALE_RESET;
      sigma_accum  <= ACC_INIT;
      swap_toggle  <= 1'b0;
      m_tvalid     <= 1'b0;
      cnt          <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          hpwm_pkg::REG_PERIOD_COUNT: period_count <= cfg_data;
          hpwm_pkg::REG_MEP_SCALE:    mep_scale    <= cfg_data;
          default: ;
        endcase
      end
      if (state == hpwm_pkg::ST_MUL1 || state == hpwm_pkg::ST_MUL2) cnt <= cnt + 1'b1;
      else cnt <= '0;
      if (state == hpwm_pkg::ST_SIG1 || state == hpwm_pkg::ST_SIG2) sigma_accum <= sigma_sum;
      if (state == hpwm_pkg::ST_FIN && out_free) begin
        m_tvalid    <= 1'b1;
        swap_toggle <= ~swap_toggle;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    unique case (state)
      hpwm_pkg::ST_IDLE: begin
        mcand  <= s_tdata;
        mplier <= (period_count < hpwm_pkg::MIN_PERIOD) ? hpwm_pkg::MIN_PERIOD : period_count;
        prod   <= '0;
      end
      hpwm_pkg::ST_MUL1: begin
        if (mul_last) begin
          coarse <= mul_step[hpwm_pkg::PROD_W-1:hpwm_pkg::DUTY_W];
          mcand  <= mul_step[hpwm_pkg::DUTY_W-1:0];
          mplier <= mep_scale;
          prod   <= '0;
        end else begin
          prod   <= mul_step;
          mplier <= mplier >> 1;
        end
      end
      hpwm_pkg::ST_MUL2: begin
        prod   <= mul_step;
        mplier <= mplier >> 1;
        if (mul_last) fine <= mul_step[hpwm_pkg::PROD_W-1:hpwm_pkg::DUTY_W];
      end
      hpwm_pkg::ST_SIG1: first_bit <= sigma_sum[ACC_W-1];
      hpwm_pkg::ST_SIG2: ;
      hpwm_pkg::ST_FIN: begin
        if (out_free) begin
          m_tdata[hpwm_pkg::COARSE_W-1:0] <= coarse;
          if (swap_toggle) begin
            m_tdata[hpwm_pkg::COARSE_W +: hpwm_pkg::STEP_W] <= step_first;
            m_tdata[hpwm_pkg::COARSE_W + hpwm_pkg::STEP_W +: hpwm_pkg::STEP_W] <= step_second;
          end else begin
            m_tdata[hpwm_pkg::COARSE_W +: hpwm_pkg::STEP_W] <= step_second;
            m_tdata[hpwm_pkg::COARSE_W + hpwm_pkg::STEP_W +: hpwm_pkg::STEP_W] <= step_first;
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // one item at a time: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // the pass counter only runs inside the multiply states
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state == hpwm_pkg::ST_IDLE || state == hpwm_pkg::ST_FIN) |-> cnt == '0)
    else $error("multiply counter not cleared");

  // the two dithered steps never differ by more than one
  a_step_gap: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |->
      (m_tdata[23:16] == m_tdata[31:24]) ||
      (m_tdata[23:16] == m_tdata[31:24] + 8'd1) ||
      (m_tdata[31:24] == m_tdata[23:16] + 8'd1))
    else $error("fine steps differ by more than one");
`endif

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for hires_pwm_duty_sigma_delta: duty items stream in, and each
// result is checked against an in-bench duty/dither predictor. Depends on hpwm_pkg.
module tb;

  localparam int ACC_W = hpwm_pkg::SIGMA_FRAC_BITS_DEF + 2;
  localparam logic [ACC_W-1:0] ACC_TOP     = ACC_W'(1) << (ACC_W - 1);
  localparam logic [ACC_W-1:0] SIGMA_DELTA = ACC_W'(3) << hpwm_pkg::SIGMA_FRAC_BITS_DEF;
  localparam logic [hpwm_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
  localparam logic [hpwm_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD   = 600;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASE_ITEMS = 166;

  // coarse_count [15:0], fine_step_a [23:16], fine_step_b [31:24]
  typedef struct packed {
    logic [hpwm_pkg::STEP_W-1:0]   step_b;
    logic [hpwm_pkg::STEP_W-1:0]   step_a;
    logic [hpwm_pkg::COARSE_W-1:0] coarse;
  } duty_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic [hpwm_pkg::DUTY_W-1:0]     s_tdata = '0;  // duty_ratio [31:0]
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  // coarse_count [15:0], fine_step_a [23:16], fine_step_b [31:24]
  logic [hpwm_pkg::OUT_W-1:0]      m_tdata;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [hpwm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hpwm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  hires_pwm_duty_sigma_delta u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [ACC_W-1:0]              dither_acc;
  logic                          dither_swap;
  logic [hpwm_pkg::PERIOD_W-1:0] period_shadow;
  logic [hpwm_pkg::SCALE_W-1:0]  scale_shadow;

  logic [hpwm_pkg::DUTY_W-1:0] duty_backlog[$];
  duty_result_t      pending_res[$];
  int                n_pushed = 0;
  int                n_accepted = 0;
  int                err_cnt = 0;
  int                cycle_cnt = 0;
  logic              s_fire = 1'b0;
  logic              tx_gaps = 1'b0;
  logic              rx_gaps = 1'b0;
  logic              rx_hold = 1'b0;
  int                tx_wait = 0;
  int                rx_stall = 0;
  event              start_hold;

  function automatic duty_result_t compute_duty_steps(
      input logic [hpwm_pkg::DUTY_W-1:0] duty);
    logic [hpwm_pkg::PERIOD_W-1:0] per;
    logic [hpwm_pkg::PROD_W-1:0]   prod;
    logic [63:0]                   fine_wide;
    logic [hpwm_pkg::FINE_W-1:0]   fine;
    logic [hpwm_pkg::STEP_W-1:0]   base;
    logic [ACC_W-1:0]              acc;
    logic                          bit1, bit2;
    duty_result_t                  r;
    per = (period_shadow < hpwm_pkg::MIN_PERIOD) ? hpwm_pkg::MIN_PERIOD : period_shadow;
    prod = hpwm_pkg::PROD_W'(duty) * hpwm_pkg::PROD_W'(per);
    fine_wide = 64'(prod[31:0]) * 64'(scale_shadow);
    fine = fine_wide[47:32];
    base = fine[hpwm_pkg::FINE_W-1:hpwm_pkg::STEP_W];
    acc = dither_acc;
    acc = acc + ACC_W'(fine[hpwm_pkg::STEP_W-1:0]) + (acc[ACC_W-1] ? SIGMA_DELTA : '0);
    bit1 = acc[ACC_W-1];
    // second pass feeds back the first dither bit, and its sum is kept
    acc = acc + ACC_W'(fine[hpwm_pkg::STEP_W-1:0]) + (bit1 ? SIGMA_DELTA : '0);
    bit2 = acc[ACC_W-1];
    dither_acc = acc;
    r.coarse = prod[hpwm_pkg::PROD_W-1:32];
    if (dither_swap) begin
      r.step_a = base + hpwm_pkg::STEP_W'(bit1);
      r.step_b = base + hpwm_pkg::STEP_W'(bit2);
    end else begin
      r.step_b = base + hpwm_pkg::STEP_W'(bit1);
      r.step_a = base + hpwm_pkg::STEP_W'(bit2);
    end
    dither_swap = ~dither_swap;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= 50)
      $display("mismatch @%0t: %s got %h want %h", $time, what, got, want);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [hpwm_pkg::DUTY_W-1:0] pick_duty();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? '1 : '0;
      1: return hpwm_pkg::DUTY_W'($urandom_range(0, 255));
      2: return ~hpwm_pkg::DUTY_W'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_fire) begin
      if (tx_wait != 0) begin
        s_tvalid <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (duty_backlog.size() != 0) begin
        s_tdata <= duty_backlog.pop_front();
        s_tvalid <= 1'b1;
        if (tx_gaps) tx_wait <= gap_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold) begin
      m_tready <= 1'b0;
    end else if (rx_stall != 0) begin
      m_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      m_tready <= 1'b1;
      if (rx_gaps && $urandom_range(0, 5) == 0) rx_stall <= stall_len();
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  always begin
    @(start_hold);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold = 1'b0;
  end

  // monitor and checker
  always @(posedge clk) begin
    duty_result_t got, want;
    if (rst) begin
      dither_acc = ACC_TOP;
      dither_swap = 1'b0;
      period_shadow = hpwm_pkg::PERIOD_RESET;
      scale_shadow = hpwm_pkg::SCALE_RESET;
      s_fire <= 1'b0;
    end else begin
      s_fire <= s_tvalid && s_tready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hpwm_pkg::REG_PERIOD_COUNT: period_shadow = cfg_data;
          hpwm_pkg::REG_MEP_SCALE:    scale_shadow = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        pending_res.push_back(compute_duty_steps(s_tdata));
        n_accepted++;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_res.size() == 0) begin
          report_mismatch("item with none pending", m_tdata, '0);
        end else begin
          want = pending_res.pop_front();
          if (got.coarse !== want.coarse)
            report_mismatch("coarse_count", 32'(got.coarse), 32'(want.coarse));
          if (got.step_a !== want.step_a)
            report_mismatch("fine_step_a", 32'(got.step_a), 32'(want.step_a));
          if (got.step_b !== want.step_b)
            report_mismatch("fine_step_b", 32'(got.step_b), 32'(want.step_b));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic push_duty(input logic [hpwm_pkg::DUTY_W-1:0] d);
    duty_backlog.push_back(d);
    n_pushed++;
  endtask

  // counters move at the rising edge, so checking at the falling edge is race-free
  task automatic wait_drained();
    do @(negedge clk);
    while (n_accepted != n_pushed || pending_res.size() != 0);
  endtask

  task automatic write_reg(input logic [hpwm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hpwm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [hpwm_pkg::PERIOD_W-1:0] per_pick[8];
    logic [hpwm_pkg::SCALE_W-1:0]  scale_pick[8];
    per_pick   = '{16'd0, 16'hFFFF, 16'd16, 16'($urandom), 16'd15, 16'($urandom),
                   16'd17, 16'($urandom)};
    scale_pick = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'($urandom), 16'h8000, 16'($urandom),
                   16'hFFFF, 16'($urandom)};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: scale 0 gives no fine step
    push_duty(32'h0000_0000);
    push_duty(32'hFFFF_FFFF);
    push_duty(32'h8000_0000);
    push_duty(32'h0000_0001);
    wait_drained();

    // short period clamps to 16; base of 255 plus a dither bit wraps to 0
    write_reg(hpwm_pkg::REG_PERIOD_COUNT, 16'd0);
    write_reg(hpwm_pkg::REG_MEP_SCALE, 16'hFFFF);
    repeat (4) push_duty(32'h0FFF_FFFF);
    push_duty(32'hFFFF_FFFF);
    push_duty(32'h0000_0000);
    wait_drained();

    // writes to unknown indexes must leave the settings alone
    write_reg(hpwm_pkg::REG_PERIOD_COUNT, 16'd15);
    write_reg(REG_UNUSED_LO, 16'h1234);
    write_reg(REG_UNUSED_HI, 16'hFFFF);
    push_duty(32'h1234_5678);
    push_duty(32'h0FFF_FFFF);
    wait_drained();

    write_reg(hpwm_pkg::REG_PERIOD_COUNT, 16'd16);
    write_reg(hpwm_pkg::REG_MEP_SCALE, 16'h8000);
    push_duty(32'hAAAA_AAAA);
    push_duty(32'h5555_5555);
    wait_drained();

    write_reg(hpwm_pkg::REG_PERIOD_COUNT, 16'hFFFF);
    write_reg(hpwm_pkg::REG_MEP_SCALE, 16'hFFFF);
    push_duty(32'hFFFF_FFFF);
    push_duty(32'h0000_0001);
    push_duty(32'h8000_0000);
    push_duty(32'hDEAD_BEEF);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(hpwm_pkg::REG_PERIOD_COUNT, per_pick[ph]);
      write_reg(hpwm_pkg::REG_MEP_SCALE, scale_pick[ph]);
      if ($urandom_range(0, 2) == 0)
        write_reg(hpwm_pkg::CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                  16'($urandom));
      // phase 1 runs with no idling on either side
      tx_gaps = (ph != 1);
      rx_gaps = (ph != 1);
      for (int n = 0; n < PHASE_ITEMS; n++) push_duty(pick_duty());
      if (ph == 3) -> start_hold;
      wait_drained();
      // sender sits out a while with nothing pending
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_res.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

### filelist.f
src/hpwm_pkg.sv
src/hires_pwm_duty_sigma_delta.sv
dv/tb.sv
